// ===== hdl/fir_pkg.sv =====
// ----------------------------------------------------------------------------
// fir_pkg
// Types, widths and coefficients shared by the 11-tap saturating FIR filter.
// ----------------------------------------------------------------------------
package fir_pkg;

	localparam int TAPS        = 11;
	localparam int SAMPLE_BITS = 9;
	localparam int COEF_BITS   = 8;
	localparam int COUNT_BITS  = $clog2(TAPS + 1);
	localparam int PROD_BITS   = SAMPLE_BITS + COEF_BITS;
	localparam int SHIFT       = SAMPLE_BITS + 1;
	localparam int TERM_BITS   = PROD_BITS - SHIFT;
	localparam int ACC_BITS    = TERM_BITS + $clog2(TAPS);
	localparam int SCALED_BITS = ACC_BITS + 2;

	typedef logic signed [SAMPLE_BITS-1:0] sample_t;
	typedef logic signed [COEF_BITS-1:0]   coef_t;
	typedef sample_t [TAPS-1:0]            tap_vec_t;
	typedef logic [COUNT_BITS-1:0]         count_t;

	localparam coef_t COEFS [TAPS] = '{
		-8'sd1, -8'sd4, -8'sd7, 8'sd16, 8'sd70, 8'sd101,
		8'sd70, 8'sd16, -8'sd7, -8'sd4, -8'sd1
	};

	typedef struct packed {
		sample_t sample;
		logic    sample_valid;
	} fir_in_t;

	typedef struct packed {
		sample_t filtered;
		logic    out_valid;
	} fir_out_t;

	// Status of the item held in the first stage
	typedef struct packed {
		logic busy;
		logic out_valid;
	} fir_stat_t;

endpackage

// ===== hdl/fir_in_if.sv =====
// ----------------------------------------------------------------------------
// fir_in_if
// Sample channel: valid/ready handshake carrying one sample item.
// ----------------------------------------------------------------------------
interface fir_in_if import fir_pkg::*; ();
	logic    valid;
	logic    ready;
	fir_in_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// ===== hdl/fir_out_if.sv =====
// ----------------------------------------------------------------------------
// fir_out_if
// Result channel: valid/ready handshake carrying one filter result.
// ----------------------------------------------------------------------------
interface fir_out_if import fir_pkg::*; ();
	logic     valid;
	logic     ready;
	fir_out_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// ===== hdl/fir_tap_line.sv =====
// ----------------------------------------------------------------------------
// fir_tap_line
// Delay line, saturating valid-sample count and first-stage item register.
// ----------------------------------------------------------------------------
module fir_tap_line import fir_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      accept,
	input  logic      advance,
	input  fir_in_t   item,
	output tap_vec_t  taps,
	output fir_stat_t stat
);

	tap_vec_t taps_q;
	count_t   count_q;
	count_t   count_next;
	logic     busy_s1;
	logic     out_valid_s1;

	always_comb begin
		count_next = count_q;
		if (item.sample_valid && (count_q < COUNT_BITS'(TAPS))) begin
			count_next = count_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			taps_q  <= '0;
			count_q <= '0;
		end else if (accept && item.sample_valid) begin
			taps_q  <= {taps_q[TAPS-2:0], item.sample};
			count_q <= count_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_s1      <= 1'b0;
			out_valid_s1 <= 1'b0;
		end else if (accept) begin
			busy_s1      <= 1'b1;
			out_valid_s1 <= item.sample_valid && (count_next >= COUNT_BITS'(TAPS));
		end else if (advance) begin
			busy_s1 <= 1'b0;
		end
	end

	assign taps           = taps_q;
	assign stat.busy      = busy_s1;
	assign stat.out_valid = out_valid_s1;

endmodule

// ===== hdl/fir_mac.sv =====
// ----------------------------------------------------------------------------
// fir_mac
// Constant-coefficient products, floor scaling, sum and saturation.
// ----------------------------------------------------------------------------
module fir_mac import fir_pkg::*; (
	input  tap_vec_t taps,
	output sample_t  filtered
);

	localparam logic signed [SCALED_BITS-1:0] SAT_MAX = SCALED_BITS'(2**(SAMPLE_BITS-1) - 1);
	localparam logic signed [SCALED_BITS-1:0] SAT_MIN = -SCALED_BITS'(2**(SAMPLE_BITS-1));

	logic signed [PROD_BITS-1:0]   prod [TAPS];
	logic signed [ACC_BITS-1:0]    acc;
	logic signed [SCALED_BITS-1:0] scaled;

	// Widen both operands first so the product keeps every bit
	always_comb begin
		for (int i = 0; i < TAPS; i++) begin
			prod[i] = PROD_BITS'(taps[i]) * PROD_BITS'(COEFS[i]);
		end
	end

	// Drop the low bits of each product: floor toward minus infinity
	always_comb begin
		acc = '0;
		for (int i = 0; i < TAPS; i++) begin
			acc = acc + ACC_BITS'($signed(prod[i][PROD_BITS-1:SHIFT]));
		end
	end

	always_comb begin
		scaled = {acc, 2'b00};
		if (scaled > SAT_MAX) begin
			filtered = SAT_MAX[SAMPLE_BITS-1:0];
		end else if (scaled < SAT_MIN) begin
			filtered = SAT_MIN[SAMPLE_BITS-1:0];
		end else begin
			filtered = scaled[SAMPLE_BITS-1:0];
		end
	end

endmodule

// ===== hdl/fir_filter_11_tap_saturating.sv =====
// ----------------------------------------------------------------------------
// fir_filter_11_tap_saturating
// Direct-form 11-tap FIR with fixed symmetric coefficients and saturation.
// ----------------------------------------------------------------------------
// Usage:
//   samples : sink channel, one item per beat (sample, sample_valid).
//   results : source channel, one item per accepted sample (filtered,
//             out_valid).
//   A sample item with sample_valid set shifts into the delay line; an item
//   with sample_valid clear leaves the line alone but still yields a result.
//   out_valid is set only for valid items once eleven valid samples arrived.
//   Path: a sample beat is held in the first-stage register and its result then
//   in the result register, from which it is offered on results.
//   Throughput: one item per cycle unless results stalls; the eleven tap
//   products are summed combinationally from first stage to result register.
//   When results stalls, the result register holds and the first stage
//   keeps one more item; samples.ready then drops until results moves.
//   Reset zeroes the delay line, the valid count and both stages' flags.
// ----------------------------------------------------------------------------
module fir_filter_11_tap_saturating import fir_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	fir_in_if.sink           samples,
	fir_out_if.source        results
);

	tap_vec_t  taps;
	fir_stat_t stat;
	sample_t   filtered;
	logic      out_free;
	logic      advance;
	logic      accept;
	logic      res_valid_q;
	fir_out_t  res_q;

	assign out_free      = !res_valid_q || results.ready;
	assign advance       = stat.busy && out_free;
	assign samples.ready = !stat.busy || out_free;
	assign accept        = samples.valid && samples.ready;

	fir_tap_line u_tap_line (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.advance (advance),
		.item    (samples.data),
		.taps    (taps),
		.stat    (stat)
	);

	fir_mac u_mac (
		.taps     (taps),
		.filtered (filtered)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (out_free) begin
			res_valid_q <= stat.busy;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q.filtered  <= filtered;
			res_q.out_valid <= stat.out_valid;
		end
	end

	assign results.valid = res_valid_q;
	assign results.data  = res_q;

endmodule

// ===== sim/fir_filter_11_tap_saturating_checker.sv =====
// ----------------------------------------------------------------------------
// fir_filter_11_tap_saturating_checker
// Watches both channels of the FIR, predicts the result of every sample beat
// from its own delay line and compares each result beat in arrival order.
// ----------------------------------------------------------------------------
module fir_filter_11_tap_saturating_checker import fir_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	fir_in_if    samples,
	fir_out_if   results,
	output int   mismatches,
	output int   pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int OUT_HI = 2 ** (SAMPLE_BITS - 1) - 1;
	localparam int OUT_LO = -(2 ** (SAMPLE_BITS - 1));

	sample_t     line_taps [TAPS];
	int unsigned valid_seen;
	fir_out_t    filtered_q [$];
	fir_out_t    want;
	fir_out_t    got;
	int          errs;

	// Advance the delay line on a valid beat and return the filtered result.
	function automatic fir_out_t filter_step(fir_in_t beat);
		int       acc;
		fir_out_t res;
		if (beat.sample_valid) begin
			for (int i = TAPS - 1; i > 0; i--)
				line_taps[i] = line_taps[i - 1];
			line_taps[0] = beat.sample;
			if (valid_seen < TAPS)
				valid_seen++;
		end
		acc = 0;
		// floor shift of each product: >>> on a signed int rounds down
		for (int i = 0; i < TAPS; i++)
			acc += (int'(line_taps[i]) * int'(COEFS[i])) >>> SHIFT;
		acc = acc * 4;
		if (acc > OUT_HI)
			acc = OUT_HI;
		else if (acc < OUT_LO)
			acc = OUT_LO;
		res.filtered  = sample_t'(acc);
		res.out_valid = beat.sample_valid && (valid_seen >= TAPS);
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TAPS; i++)
				line_taps[i] = '0;
			valid_seen = 0;
			filtered_q.delete();
			errs = 0;
			mismatches <= 0;
			pending <= 0;
		end else begin
			if (samples.valid && samples.ready)
				filtered_q.push_back(filter_step(samples.data));
			if (results.valid && results.ready) begin
				got = results.data;
				if (filtered_q.size() == 0) begin
					$error("result beat with no sample pending: filtered %0d out_valid %0b",
						got.filtered, got.out_valid);
					errs++;
				end else begin
					want = filtered_q.pop_front();
					if (got.filtered !== want.filtered) begin
						$error("filtered: expected %0d, got %0d", want.filtered, got.filtered);
						errs++;
					end
					if (got.out_valid !== want.out_valid) begin
						$error("out_valid: expected %0b, got %0b", want.out_valid,
							got.out_valid);
						errs++;
					end
				end
			end
			mismatches <= errs;
			pending <= filtered_q.size();
		end
	end

endmodule

// ===== sim/fir_filter_11_tap_saturating_test.sv =====
// ----------------------------------------------------------------------------
// fir_filter_11_tap_saturating_test
// Drives sample beats into the 11-tap saturating FIR (directed extremes, then
// random runs with idle gaps and a long result stall) and gives the verdict
// from the checker's mismatch and pending counts.
// ----------------------------------------------------------------------------
module fir_filter_11_tap_saturating_test import fir_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int      CYCLE_LIMIT  = 100000;
	localparam int      RANDOM_ITEMS = 1825;
	localparam int      STALL_CYCLES = 64;
	localparam sample_t SAMPLE_MAX   = sample_t'(2 ** (SAMPLE_BITS - 1) - 1);
	localparam sample_t SAMPLE_MIN   = sample_t'(-(2 ** (SAMPLE_BITS - 1)));

	logic clk;
	logic arst_n;
	int   mismatches;
	int   pending;
	bit   src_idle_en = 1'b1;
	bit   snk_idle_en = 1'b1;
	bit   hold_req    = 1'b0;

	fir_in_if  samples ();
	fir_out_if results ();

	fir_filter_11_tap_saturating DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.samples(samples),
		.results(results)
	);

	fir_filter_11_tap_saturating_checker scoreboard (
		.clk       (clk),
		.arst_n    (arst_n),
		.samples   (samples),
		.results   (results),
		.mismatches(mismatches),
		.pending   (pending)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("Some tests failed");
		$finish;
	end

	// Offer one beat, with random idle cycles ahead of it, and hold until taken.
	task automatic offer(input sample_t s, input logic v);
		while (src_idle_en && $urandom_range(0, 99) < 30) begin
			samples.valid <= 1'b0;
			@(posedge clk);
		end
		samples.valid <= 1'b1;
		samples.data  <= '{sample: s, sample_valid: v};
		@(posedge clk);
		while (!samples.ready)
			@(posedge clk);
	endtask

	function automatic sample_t pick_sample(input int mode, input int pos, input bit flip);
		sample_t s;
		case (mode)
			0: s = sample_t'($urandom);
			1: begin
				case ($urandom_range(0, 3))
					0: s = SAMPLE_MIN;
					1: s = SAMPLE_MAX;
					2: s = '1;
					default: s = '0;
				endcase
			end
			2: s = sample_t'($urandom_range(0, 16) - 8);
			default: begin
				// line up signs with the taps to drive the sum into a rail
				s = ((COEFS[pos] < 0) ^ flip) ? SAMPLE_MIN : SAMPLE_MAX;
				if ($urandom_range(0, 3) == 0)
					s = sample_t'($urandom);
			end
		endcase
		return s;
	endfunction

	// Result side: random back-pressure, plus a long hold when requested.
	initial begin
		results.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				results.ready <= 1'b0;
				repeat (STALL_CYCLES) @(posedge clk);
			end else begin
				results.ready <= !(snk_idle_en && $urandom_range(0, 99) < 30);
			end
		end
	end

	initial begin
		int      n;
		int      mode;
		int      pat_pos;
		bit      flip;
		logic    v;
		sample_t s;

		arst_n = 1'b0;
		samples.valid <= 1'b0;
		samples.data  <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// invalid beat on the cleared line
		offer(SAMPLE_MAX, 1'b0);
		// fill with the most negative sample; count reaches eleven, sum clamps low
		repeat (TAPS) offer(SAMPLE_MIN, 1'b1);
		// sign pattern matching the taps; sum clamps high
		for (int i = 0; i < TAPS; i++)
			offer((COEFS[i] < 0) ? SAMPLE_MIN : SAMPLE_MAX, 1'b1);
		// invalid beat on a full line, then a zero sample
		offer(SAMPLE_MIN, 1'b0);
		offer('0, 1'b1);

		mode = 0;
		pat_pos = 0;
		flip = 1'b0;
		for (n = 0; n < RANDOM_ITEMS; n++) begin
			if (n == 300) begin
				src_idle_en = 1'b0;
				snk_idle_en = 1'b0;
			end
			// keep offering while the result side holds off
			if (n == 400)
				hold_req = 1'b1;
			if (n == 550) begin
				src_idle_en = 1'b1;
				snk_idle_en = 1'b1;
			end
			if (n % 25 == 0) begin
				mode = $urandom_range(0, 3);
				flip = $urandom_range(0, 1);
			end
			v = ($urandom_range(0, 99) < 88);
			s = pick_sample(mode, pat_pos, flip);
			if (v)
				pat_pos = (pat_pos + 1) % TAPS;
			offer(s, v);
		end
		samples.valid <= 1'b0;

		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatches == 0 && pending == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
